// ----- rtl/hill_dale_extent_tracker_assert.svh -----
// Assertion macros used by the checker module of the hill/dale tracker.
// Plain text macros only; no dependencies.
`ifndef HILL_DALE_EXTENT_TRACKER_ASSERT_SVH
`define HILL_DALE_EXTENT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define HDX_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("hill_dale_extent_tracker assertion failed");

// Next-cycle implication, disabled while dis is high.
`define HDX_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("hill_dale_extent_tracker assertion failed");

`endif

// ----- rtl/hdx_pkg.sv -----
// Package for the hill/dale extent tracker: widths, queue item type and
// small arithmetic helpers. No dependencies.
package hdx_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int OUT_BITS    = 32;
    localparam int EXT_BITS    = (DIFF_BITS > OUT_BITS) ? DIFF_BITS : OUT_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DIFF_BITS-1:0]          diff_t;
    typedef logic [OUT_BITS-1:0]           out_t;

    // Closed peak and valley scores produced by one sample, plus the end mark.
    typedef struct packed {
        logic  peak_vld;
        diff_t peak_left;
        diff_t peak_right;
        logic  valley_vld;
        diff_t valley_left;
        diff_t valley_right;
        logic  last;
    } event_t;

    // Distance hi - lo of two signed samples; never negative where it is used.
    function automatic diff_t span(sample_t hi, sample_t lo);
        diff_t hi_x;
        diff_t lo_x;
        hi_x = {hi[SAMPLE_BITS-1], hi};
        lo_x = {lo[SAMPLE_BITS-1], lo};
        return hi_x - lo_x;
    endfunction

    function automatic diff_t min_d(diff_t a, diff_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic diff_t max_d(diff_t a, diff_t b);
        return (a > b) ? a : b;
    endfunction

    // Clamp a score to the output field width.
    function automatic out_t sat_out(diff_t v);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v);
        if (|ext[EXT_BITS-1:OUT_BITS]) begin
            return '1;
        end
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/hdx_front.sv -----
// Front end of the hill/dale tracker: follows the rising and falling runs
// and emits closed peak and valley scores. Uses hdx_pkg.
module hdx_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hdx_pkg::sample_t s_sample,
    input  logic             s_last,
    output logic             ev_valid,
    input  logic             ev_ready,
    output hdx_pkg::event_t  ev
);

    hdx_pkg::sample_t prev_reg, rise_reg, fall_reg;
    hdx_pkg::sample_t rise_next, fall_next;
    logic             started_reg;
    logic             peak_pend_reg, peak_pend_next;
    logic             valley_pend_reg, valley_pend_next;
    hdx_pkg::diff_t   peak_rise_reg, peak_rise_next;
    hdx_pkg::diff_t   valley_drop_reg, valley_drop_next;

    logic             gt, lt, rising, falling, step_peak, step_valley, accept;
    hdx_pkg::diff_t   fall_p, p_rise, fall_x, p_x, x_rise, x_p;

    assign s_ready = ev_ready;
    assign accept  = s_valid && ev_ready;

    assign gt      = s_sample > prev_reg;
    assign lt      = s_sample < prev_reg;
    assign rising  = rise_reg != prev_reg;
    assign falling = fall_reg != prev_reg;

    assign fall_p = hdx_pkg::span(fall_reg, prev_reg);
    assign p_rise = hdx_pkg::span(prev_reg, rise_reg);
    assign fall_x = hdx_pkg::span(fall_reg, s_sample);
    assign p_x    = hdx_pkg::span(prev_reg, s_sample);
    assign x_rise = hdx_pkg::span(s_sample, rise_reg);
    assign x_p    = hdx_pkg::span(s_sample, prev_reg);

    always_comb begin
        rise_next        = rise_reg;
        fall_next        = fall_reg;
        peak_pend_next   = peak_pend_reg;
        peak_rise_next   = peak_rise_reg;
        valley_pend_next = valley_pend_reg;
        valley_drop_next = valley_drop_reg;
        step_peak        = 1'b0;
        step_valley      = 1'b0;
        if (!started_reg) begin
            rise_next = s_sample;
            fall_next = s_sample;
        end else if (gt) begin
            if (falling) begin
                valley_pend_next = 1'b1;
                valley_drop_next = fall_p;
            end
            step_peak      = peak_pend_reg;
            peak_pend_next = 1'b0;
            if (!rising) begin
                rise_next = prev_reg;
            end
            fall_next = s_sample;
        end else if (lt) begin
            if (rising) begin
                peak_pend_next = 1'b1;
                peak_rise_next = p_rise;
            end
            step_valley      = valley_pend_reg;
            valley_pend_next = 1'b0;
            if (!falling) begin
                fall_next = prev_reg;
            end
            rise_next = s_sample;
        end else begin
            // A plateau closes whatever is pending and starts no run.
            step_peak        = peak_pend_reg;
            step_valley      = valley_pend_reg;
            peak_pend_next   = 1'b0;
            valley_pend_next = 1'b0;
            rise_next        = s_sample;
            fall_next        = s_sample;
        end
    end

    // A peak or valley still open on the last sample is closed at that sample.
    always_comb begin
        ev.peak_vld     = step_peak || (s_last && peak_pend_next);
        ev.peak_left    = step_peak ? peak_rise_reg : peak_rise_next;
        ev.peak_right   = step_peak ? fall_p : (falling ? fall_x : p_x);
        ev.valley_vld   = step_valley || (s_last && valley_pend_next);
        ev.valley_left  = step_valley ? valley_drop_reg : valley_drop_next;
        ev.valley_right = step_valley ? p_rise : (rising ? x_rise : x_p);
        ev.last         = s_last;
    end

    assign ev_valid = s_valid && (ev.peak_vld || ev.valley_vld || s_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg     <= 1'b0;
            peak_pend_reg   <= 1'b0;
            valley_pend_reg <= 1'b0;
        end else if (accept) begin
            started_reg     <= !s_last;
            peak_pend_reg   <= peak_pend_next && !s_last;
            valley_pend_reg <= valley_pend_next && !s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg        <= s_sample;
            rise_reg        <= rise_next;
            fall_reg        <= fall_next;
            peak_rise_reg   <= peak_rise_next;
            valley_drop_reg <= valley_drop_next;
        end
    end

endmodule

// ----- rtl/hdx_queue.sv -----
// Short queue of score transactions between front and back of the tracker.
// Uses hdx_pkg.
module hdx_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  hdx_pkg::event_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output hdx_pkg::event_t out_item
);

    hdx_pkg::event_t                  slot_reg [hdx_pkg::QUEUE_DEPTH];
    logic [hdx_pkg::PTR_BITS-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [hdx_pkg::CNT_BITS-1:0]     count_reg;
    logic                             push, pop;

    assign in_ready  = count_reg != hdx_pkg::CNT_BITS'(hdx_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [hdx_pkg::PTR_BITS-1:0] bump(
        logic [hdx_pkg::PTR_BITS-1:0] ptr);
        if (ptr == hdx_pkg::PTR_BITS'(hdx_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/hdx_back.sv -----
// Back end of the hill/dale tracker: scores each closed peak and valley,
// keeps the running maxima and holds the result register. Uses hdx_pkg.
module hdx_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  hdx_pkg::event_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output hdx_pkg::out_t   m_max_height,
    output hdx_pkg::out_t   m_max_depth
);

    logic           a_vld_reg, a_last_reg;
    hdx_pkg::diff_t a_height_reg, a_depth_reg;
    hdx_pkg::diff_t best_height_reg, best_depth_reg;
    hdx_pkg::diff_t height_next, depth_next;
    logic           m_valid_reg;
    hdx_pkg::out_t  m_height_reg, m_depth_reg;
    logic           b_take, pop;

    // The end-of-sequence transaction waits in stage A until the result
    // register is free; everything else passes straight through.
    assign b_take  = a_vld_reg && (!a_last_reg || !m_valid_reg || m_ready);
    assign q_ready = !a_vld_reg || b_take;
    assign pop     = q_valid && q_ready;

    assign height_next = hdx_pkg::max_d(best_height_reg, a_height_reg);
    assign depth_next  = hdx_pkg::max_d(best_depth_reg, a_depth_reg);

    assign m_valid      = m_valid_reg;
    assign m_max_height = m_height_reg;
    assign m_max_depth  = m_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (pop) begin
            a_vld_reg <= 1'b1;
        end else if (b_take) begin
            a_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_last_reg   <= q_item.last;
            a_height_reg <= q_item.peak_vld
                ? hdx_pkg::min_d(q_item.peak_left, q_item.peak_right) : '0;
            a_depth_reg  <= q_item.valley_vld
                ? hdx_pkg::min_d(q_item.valley_left, q_item.valley_right) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_height_reg <= '0;
            best_depth_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (b_take) begin
                if (a_last_reg) begin
                    best_height_reg <= '0;
                    best_depth_reg  <= '0;
                end else begin
                    best_height_reg <= height_next;
                    best_depth_reg  <= depth_next;
                end
            end
            if (b_take && a_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_take && a_last_reg) begin
            m_height_reg <= hdx_pkg::sat_out(height_next);
            m_depth_reg  <= hdx_pkg::sat_out(depth_next);
        end
    end

endmodule

// ----- rtl/hill_dale_extent_tracker.sv -----
// Channel  Direction  Ports                               Meaning
// s_       in         s_valid s_ready s_sample s_last     one sample, last marks sequence end
// m_       out        m_valid m_ready m_max_height/depth  one result per sequence
//
// One sample is taken every cycle while s_ready is high; the result of a sequence reaches m_
// through the queue entry, the score stage and the result register.
// Reset (aresetn low at a clock edge) clears all run tracking and maxima.
// Only a result held on a stalled m_ side stops the back end; the queue then fills
// and s_ready drops, with no transaction lost.
// Top level of the hill/dale tracker; uses hdx_pkg, hdx_front, hdx_queue, hdx_back.
module hill_dale_extent_tracker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [hdx_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hdx_pkg::OUT_BITS-1:0]          m_max_height,
    output logic [hdx_pkg::OUT_BITS-1:0]          m_max_depth
);

    logic            ev_valid, ev_ready, q_valid, q_ready;
    hdx_pkg::event_t ev, q_item;

    hdx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .s_last   (s_last),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    hdx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ev_valid),
        .in_ready  (ev_ready),
        .in_item   (ev),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    hdx_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_max_height (m_max_height),
        .m_max_depth  (m_max_depth)
    );

endmodule

// ----- rtl/hdx_checker.sv -----
// Port-level checks for the hill/dale tracker, bound to the top level.
// Uses hdx_pkg and the macros of hill_dale_extent_tracker_assert.svh.
`include "hill_dale_extent_tracker_assert.svh"

module hdx_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_last,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [hdx_pkg::OUT_BITS-1:0]          m_max_height,
    input logic [hdx_pkg::OUT_BITS-1:0]          m_max_depth
);

    logic       last_accept, result_accept;
    logic [2:0] pend_reg, pend_next;

    assign last_accept   = s_valid && s_ready && s_last;
    assign result_accept = m_valid && m_ready;

    // Number of finished sequences whose result has not been taken yet.
    always_comb begin
        pend_next = pend_reg;
        if (last_accept && !result_accept) begin
            pend_next = pend_reg + 3'd1;
        end else if (!last_accept && result_accept) begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // The input side only stalls while a finished result waits to be taken.
    `HDX_ASSERT_NOW(a_stall_needs_result, aclk, !aresetn, !s_ready, m_valid)

    `HDX_ASSERT_NEXT(a_reset_clears_result, aclk, 1'b0, !aresetn, !m_valid)

    // Every result belongs to a sequence whose last transaction was taken earlier.
    `HDX_ASSERT_NOW(a_result_has_source, aclk, !aresetn, m_valid, pend_reg != 3'd0)

    `HDX_ASSERT_NEXT(a_result_held, aclk, !aresetn, m_valid && !m_ready,
        m_valid && $stable(m_max_height) && $stable(m_max_depth))

endmodule

bind hill_dale_extent_tracker hdx_checker u_hdx_checker (.*);

// ----- tb/sv/tb_hill_dale_extent_tracker.sv -----
// Testbench for hill_dale_extent_tracker: directed and random sample sequences,
// with a scoreboard that predicts the per-sequence maximum hill height and dale depth.
// Depends on hdx_pkg and the hill_dale_extent_tracker RTL.
module tb_hill_dale_extent_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      RANDOM_ITEMS = 700;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      TAIL_CYCLES  = 8;
    localparam hdx_pkg::sample_t SAMPLE_MIN =
        {1'b1, {(hdx_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam hdx_pkg::sample_t SAMPLE_MAX =
        {1'b0, {(hdx_pkg::SAMPLE_BITS-1){1'b1}}};

    typedef struct packed {
        hdx_pkg::out_t height;
        hdx_pkg::out_t depth;
    } extent_t;

    // Tracks runs, peaks and valleys of the current sequence and queues the
    // extents expected when the sequence ends.
    class extent_scoreboard;
        hdx_pkg::sample_t prev_value;
        bit [1:0]         seen;
        hdx_pkg::sample_t rise_from;
        hdx_pkg::sample_t fall_from;
        bit               peak_open;
        hdx_pkg::diff_t   peak_rise;
        bit               valley_open;
        hdx_pkg::diff_t   valley_drop;
        hdx_pkg::diff_t   top_height;
        hdx_pkg::diff_t   top_depth;
        extent_t          expected_q[$];
        int               errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            prev_value  = '0;
            seen        = '0;
            rise_from   = '0;
            fall_from   = '0;
            peak_open   = 1'b0;
            peak_rise   = '0;
            valley_open = 1'b0;
            valley_drop = '0;
            top_height  = '0;
            top_depth   = '0;
        endfunction

        function hdx_pkg::diff_t span_of(hdx_pkg::sample_t hi, hdx_pkg::sample_t lo);
            return {hi[hdx_pkg::SAMPLE_BITS-1], hi} - {lo[hdx_pkg::SAMPLE_BITS-1], lo};
        endfunction

        function hdx_pkg::out_t clamp(hdx_pkg::diff_t v);
            if (64'(v) > 64'hFFFF_FFFF) begin
                return '1;
            end
            return hdx_pkg::out_t'(v);
        endfunction

        function void close_peak(hdx_pkg::sample_t end_value);
            hdx_pkg::diff_t right;
            hdx_pkg::diff_t h;
            if (peak_open) begin
                right = span_of(fall_from, end_value);
                h = (peak_rise < right) ? peak_rise : right;
                if (h > top_height) top_height = h;
                peak_open = 1'b0;
            end
        endfunction

        function void close_valley(hdx_pkg::sample_t end_value);
            hdx_pkg::diff_t right;
            hdx_pkg::diff_t d;
            if (valley_open) begin
                right = span_of(end_value, rise_from);
                d = (valley_drop < right) ? valley_drop : right;
                if (d > top_depth) top_depth = d;
                valley_open = 1'b0;
            end
        endfunction

        function void note_input(hdx_pkg::sample_t x, bit is_last);
            hdx_pkg::sample_t p;
            bit               rising;
            bit               falling;
            extent_t          res;
            if (seen == 0) begin
                rise_from = x;
                fall_from = x;
            end else begin
                p       = prev_value;
                rising  = (rise_from != p);
                falling = (fall_from != p);
                if (x > p) begin
                    if (falling) begin
                        valley_open = 1'b1;
                        valley_drop = span_of(fall_from, p);
                    end
                    close_peak(p);
                    if (!rising) rise_from = p;
                    fall_from = x;
                end else if (x < p) begin
                    if (rising) begin
                        peak_open = 1'b1;
                        peak_rise = span_of(p, rise_from);
                    end
                    close_valley(p);
                    if (!falling) fall_from = p;
                    rise_from = x;
                end else begin
                    // An equal neighbor ends whatever was pending and starts no run.
                    close_peak(p);
                    close_valley(p);
                    rise_from = x;
                    fall_from = x;
                end
            end
            prev_value = x;
            if (seen < 2) seen++;
            if (is_last) begin
                close_peak(x);
                close_valley(x);
                res.height = clamp(top_height);
                res.depth  = clamp(top_depth);
                expected_q.push_back(res);
                clear();
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(hdx_pkg::out_t height, hdx_pkg::out_t depth);
            extent_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d %0d with nothing expected", height, depth));
            end else begin
                want = expected_q.pop_front();
                if (height !== want.height)
                    report_mismatch($sformatf("max_height %0d, expected %0d",
                                              height, want.height));
                if (depth !== want.depth)
                    report_mismatch($sformatf("max_depth %0d, expected %0d",
                                              depth, want.depth));
            end
        endtask
    endclass

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    hdx_pkg::sample_t s_sample     = '0;
    logic             s_last       = 1'b0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    hdx_pkg::out_t    m_max_height;
    hdx_pkg::out_t    m_max_depth;

    extent_scoreboard sb;
    hdx_pkg::sample_t seq_buf[$];
    int               items_sent  = 0;
    int               burst_left  = 0;
    int               cycle_count = 0;
    int               stall_left  = 0;
    int               stall_mode  = 0;
    int               stall_phase = 0;

    hill_dale_extent_tracker dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_max_height (m_max_height),
        .m_max_depth  (m_max_depth)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: stall pattern switches between always ready, coin flips,
    // periodic ready and long stalls.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_max_height, m_max_depth);
        end
        stall_phase <= stall_phase + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (stall_phase % 4 == 0);
            end
            default: begin
                m_ready <= (stall_phase % 12 == 0);
            end
        endcase
    end

    task automatic sender_idle(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_sample(hdx_pkg::sample_t value, bit is_last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) sender_idle($urandom_range(1, 6));
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_sample <= value;
        s_last   <= is_last;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(value, is_last);
        items_sent++;
    endtask

    task automatic send_buffer();
        foreach (seq_buf[i]) send_sample(seq_buf[i], i == seq_buf.size() - 1);
    endtask

    // Holds the sender off until every queued result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    function automatic hdx_pkg::sample_t pick_extreme();
        case ($urandom_range(0, 5))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return SAMPLE_MIN + 1;
            3: return SAMPLE_MAX - 1;
            4: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic build_random_sequence();
        int               len;
        int               style;
        hdx_pkg::sample_t v;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        style = $urandom_range(0, 3);
        v     = hdx_pkg::sample_t'($urandom);
        seq_buf = {};
        repeat (len) begin
            case (style)
                0: begin
                    v = hdx_pkg::sample_t'($urandom);
                end
                1: begin
                    // Narrow range, so equal neighbors and plateaus are common.
                    v = hdx_pkg::sample_t'($urandom_range(0, 6)) - 3;
                end
                2: begin
                    if ($urandom_range(0, 1) != 0)
                        v = v + hdx_pkg::sample_t'($urandom_range(0, 20)) - 10;
                    else
                        v = v + (hdx_pkg::sample_t'($urandom) >>> $urandom_range(0, 31));
                end
                default: begin
                    v = pick_extreme();
                end
            endcase
            seq_buf.push_back(v);
        end
    endtask

    initial begin
        int seq_count;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Sequences too short to hold a peak or a valley.
        seq_buf = '{SAMPLE_MAX};
        send_buffer();
        seq_buf = '{SAMPLE_MIN, SAMPLE_MAX};
        send_buffer();
        // Full-range hill and full-range dale.
        seq_buf = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
        send_buffer();
        seq_buf = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
        send_buffer();
        // A plateau on top cancels the peak; a plateau after the fall closes it.
        seq_buf = '{1, 5, 5, 1};
        send_buffer();
        seq_buf = '{0, 3, 1, 1};
        send_buffer();
        // A peak, and then a valley, still open when the sequence ends.
        seq_buf = '{0, 4, 2};
        send_buffer();
        seq_buf = '{0, 10, 2, 7, -5, 3};
        send_buffer();
        wait_drained();

        seq_count = 0;
        while (items_sent < RANDOM_ITEMS) begin
            build_random_sequence();
            send_buffer();
            seq_count++;
            if (seq_count % 25 == 0) wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hdx_pkg.sv
rtl/hdx_front.sv
rtl/hdx_queue.sv
rtl/hdx_back.sv
rtl/hill_dale_extent_tracker.sv
rtl/hdx_checker.sv
tb/sv/tb_hill_dale_extent_tracker.sv
